### rtl/ssi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SSI encoder reader package
// Shared types, constants and helpers for the SSI encoder frame reader.
// ----------------------------------------------------------------------------
package ssi_pkg;

    localparam int STATUS_BITS = 8;
    localparam int FIELD_W     = 6;
    localparam int TICK_W      = 16;
    localparam int VALUE_W     = 32;
    localparam int BITCNT_W    = 7;
    localparam int CFG_IDX_W   = 3;

    localparam logic [VALUE_W-1:0] ZERO_UNSET = '1;

    // word modes
    localparam logic [1:0] MODE_TICK       = 2'd0;
    localparam logic [1:0] MODE_START      = 2'd1;
    localparam logic [1:0] MODE_START_ZERO = 2'd2;
    localparam logic [1:0] MODE_LOAD_ZERO  = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MT_BITS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ST_BITS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRE_TICKS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POST_TICKS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STORED_ZERO = 3'd5;

    typedef struct packed {
        logic [FIELD_W-1:0] multiturn_bits;
        logic [FIELD_W-1:0] singleturn_bits;
        logic [TICK_W-1:0]  half_period_ticks;
        logic [TICK_W-1:0]  prelow_ticks;
        logic [TICK_W-1:0]  postlow_ticks;
        logic [VALUE_W-1:0] stored_zero;
    } t_cfg;

    typedef struct packed {
        logic                   clock_level;
        logic                   busy_res;
        logic                   frame_done;
        logic [VALUE_W-1:0]     multiturn_value;
        logic [VALUE_W-1:0]     singleturn_value;
        logic [STATUS_BITS-1:0] status_byte;
        logic [VALUE_W-1:0]     zero_offset;
    } t_result;

    // field length clamped to 1..32
    function automatic logic [FIELD_W-1:0] field_len(input logic [FIELD_W-1:0] v);
        logic [FIELD_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = FIELD_W'(1);
        end else if (v > FIELD_W'(VALUE_W)) begin
            r = FIELD_W'(VALUE_W);
        end
        return r;
    endfunction

    // zero tick count behaves as one
    function automatic logic [TICK_W-1:0] tick_len(input logic [TICK_W-1:0] v);
        return (v == '0) ? TICK_W'(1) : v;
    endfunction

endpackage
`default_nettype wire

### rtl/ssi_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SSI frame sequencer
// Clock phase sequencer, bit shifter and value/zero registers. Advances one
// tick per accepted word and presents the post-tick result combinationally.
// ----------------------------------------------------------------------------
module ssi_seq (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_adv,
    input  wire logic [1:0]      i_mode,
    input  wire logic            i_data_line,
    input  wire ssi_pkg::t_cfg   i_cfg,
    output ssi_pkg::t_result     o_next
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRELOW,
        PH_HIGH,
        PH_LOW,
        PH_POSTLOW
    } t_phase;

    t_phase                             r_phase, n_phase;
    logic [ssi_pkg::TICK_W-1:0]         r_tick, n_tick;
    logic [ssi_pkg::BITCNT_W-1:0]       r_bit, n_bit;
    logic                               r_clock, n_clock;
    logic [ssi_pkg::VALUE_W-1:0]        r_acc, n_acc;
    logic [ssi_pkg::VALUE_W-1:0]        r_mt, n_mt;
    logic [ssi_pkg::VALUE_W-1:0]        r_st, n_st;
    logic [ssi_pkg::STATUS_BITS-1:0]    r_status, n_status;
    logic [ssi_pkg::VALUE_W-1:0]        r_zero, n_zero;
    logic                               r_cap, n_cap;
    logic                               n_done;

    logic [ssi_pkg::FIELD_W-1:0]        mt_len, st_len;
    logic [ssi_pkg::BITCNT_W-1:0]       mt_end, st_end, total;
    logic [ssi_pkg::TICK_W-1:0]         len;
    logic [ssi_pkg::BITCNT_W-1:0]       bit_inc;
    logic [ssi_pkg::VALUE_W-1:0]        acc_sh;

    assign mt_len  = ssi_pkg::field_len(i_cfg.multiturn_bits);
    assign st_len  = ssi_pkg::field_len(i_cfg.singleturn_bits);
    assign mt_end  = ssi_pkg::BITCNT_W'(mt_len);
    assign st_end  = mt_end + ssi_pkg::BITCNT_W'(st_len);
    assign total   = st_end + ssi_pkg::BITCNT_W'(ssi_pkg::STATUS_BITS);
    assign bit_inc = r_bit + ssi_pkg::BITCNT_W'(1);
    assign acc_sh  = {r_acc[ssi_pkg::VALUE_W-2:0], i_data_line};

    always_comb begin
        case (r_phase)
            PH_PRELOW:         len = ssi_pkg::tick_len(i_cfg.prelow_ticks);
            PH_HIGH, PH_LOW:   len = ssi_pkg::tick_len(i_cfg.half_period_ticks);
            PH_POSTLOW:        len = ssi_pkg::tick_len(i_cfg.postlow_ticks);
            default:           len = ssi_pkg::TICK_W'(1);
        endcase
    end

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_clock  = r_clock;
        n_acc    = r_acc;
        n_mt     = r_mt;
        n_st     = r_st;
        n_status = r_status;
        n_zero   = r_zero;
        n_cap    = r_cap;
        n_done   = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_mode == ssi_pkg::MODE_START || i_mode == ssi_pkg::MODE_START_ZERO) begin
                n_phase = PH_PRELOW;
                n_tick  = ssi_pkg::TICK_W'(1);
                n_clock = 1'b0;
                n_bit   = '0;
                n_acc   = '0;
                n_cap   = (i_mode == ssi_pkg::MODE_START_ZERO);
            end
        end else if (r_tick < len) begin
            n_tick = r_tick + ssi_pkg::TICK_W'(1);
        end else begin
            case (r_phase)
                PH_PRELOW: begin
                    n_phase = PH_HIGH;
                    n_tick  = ssi_pkg::TICK_W'(1);
                    n_clock = 1'b1;
                end
                PH_HIGH: begin
                    // falling edge: sample the data line
                    n_phase = PH_LOW;
                    n_tick  = ssi_pkg::TICK_W'(1);
                    n_clock = 1'b0;
                    n_acc   = acc_sh;
                    n_bit   = bit_inc;
                    if (bit_inc == mt_end) begin
                        n_mt  = acc_sh;
                        n_acc = '0;
                    end else if (bit_inc == st_end) begin
                        n_st  = acc_sh;
                        n_acc = '0;
                    end else if (bit_inc == total) begin
                        n_status = acc_sh[ssi_pkg::STATUS_BITS-1:0];
                        n_acc    = '0;
                    end
                end
                PH_LOW: begin
                    n_phase = (r_bit >= total) ? PH_POSTLOW : PH_HIGH;
                    n_tick  = ssi_pkg::TICK_W'(1);
                    n_clock = (r_bit >= total) ? 1'b0 : 1'b1;
                end
                default: begin
                    // end of post-low: release clock
                    n_phase = PH_IDLE;
                    n_tick  = '0;
                    n_clock = 1'b1;
                    n_done  = 1'b1;
                    if (r_cap) begin
                        n_zero = r_st;
                    end
                    n_cap = 1'b0;
                end
            endcase
        end

        // stored zero load is applied last
        if (i_mode == ssi_pkg::MODE_LOAD_ZERO) begin
            n_zero = (i_cfg.stored_zero == ssi_pkg::ZERO_UNSET) ? '0 : i_cfg.stored_zero;
        end
    end

    always_comb begin
        o_next.clock_level      = n_clock;
        o_next.busy_res         = (n_phase != PH_IDLE);
        o_next.frame_done       = n_done;
        o_next.multiturn_value  = n_mt;
        o_next.singleturn_value = n_st;
        o_next.status_byte      = n_status;
        o_next.zero_offset      = n_zero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_tick   <= '0;
            r_bit    <= '0;
            r_clock  <= 1'b1;
            r_acc    <= '0;
            r_mt     <= '0;
            r_st     <= '0;
            r_status <= '0;
            r_zero   <= '0;
            r_cap    <= 1'b0;
        end else if (i_adv) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bit    <= n_bit;
            r_clock  <= n_clock;
            r_acc    <= n_acc;
            r_mt     <= n_mt;
            r_st     <= n_st;
            r_status <= n_status;
            r_zero   <= n_zero;
            r_cap    <= n_cap;
        end
    end

    a_clock_low_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PRELOW || r_phase == PH_LOW || r_phase == PH_POSTLOW) |-> !r_clock)
        else $error("encoder clock high outside the high half-period");

    a_bit_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= ssi_pkg::BITCNT_W'(2 * ssi_pkg::VALUE_W + ssi_pkg::STATUS_BITS))
        else $error("bit count beyond longest frame");

    a_done_releases: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_next.frame_done |-> (o_next.clock_level && !o_next.busy_res && r_phase == PH_POSTLOW))
        else $error("frame end without clock release");

endmodule
`default_nettype wire

### rtl/ssi_encoder_frame_reader.sv
`default_nettype none
// ----------------------------------------------------------------------------
// SSI encoder frame reader
// Top level: tick word handshake, configuration registers and result register.
// ----------------------------------------------------------------------------
// One input word is one timing tick; a word is taken each clock cycle in
// which the input does not stall, and its result word appears in the output
// register on the next cycle, so an unstalled tick stream runs at one word
// per cycle. The whole tick update (phase counter, bit shifter, zero
// handling) sits between the sequencer state and the result register. The
// input stalls only while a result word is held by a stalled output. From
// the start word a frame stays busy for prelow + 2 * half_period * bits +
// postlow ticks, with bits = multiturn + single-turn + 8; frame_done comes
// on the next word, with the clock back high. No clearing pass after reset.
module ssi_encoder_frame_reader (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tick words
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [1:0]                          i_mode,
    input  wire logic                                i_data_line,
    // result words
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_clock_level,
    output logic                                     o_busy_res,
    output logic                                     o_frame_done,
    output logic [ssi_pkg::VALUE_W-1:0]              o_multiturn_value,
    output logic [ssi_pkg::VALUE_W-1:0]              o_singleturn_value,
    output logic [ssi_pkg::STATUS_BITS-1:0]          o_status_byte,
    output logic [ssi_pkg::VALUE_W-1:0]              o_zero_offset,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [ssi_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [ssi_pkg::VALUE_W-1:0]         i_cfg_data
);

    ssi_pkg::t_cfg    r_cfg;
    ssi_pkg::t_result r_result, n_result;
    logic             r_out_valid;
    logic             in_acc;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.multiturn_bits    <= ssi_pkg::FIELD_W'(12);
            r_cfg.singleturn_bits   <= ssi_pkg::FIELD_W'(19);
            r_cfg.half_period_ticks <= ssi_pkg::TICK_W'(1);
            r_cfg.prelow_ticks      <= ssi_pkg::TICK_W'(1);
            r_cfg.postlow_ticks     <= ssi_pkg::TICK_W'(1);
            r_cfg.stored_zero       <= ssi_pkg::ZERO_UNSET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ssi_pkg::REG_MT_BITS:
                    r_cfg.multiturn_bits <= i_cfg_data[ssi_pkg::FIELD_W-1:0];
                ssi_pkg::REG_ST_BITS:
                    r_cfg.singleturn_bits <= i_cfg_data[ssi_pkg::FIELD_W-1:0];
                ssi_pkg::REG_HALF_TICKS:
                    r_cfg.half_period_ticks <= i_cfg_data[ssi_pkg::TICK_W-1:0];
                ssi_pkg::REG_PRE_TICKS:
                    r_cfg.prelow_ticks <= i_cfg_data[ssi_pkg::TICK_W-1:0];
                ssi_pkg::REG_POST_TICKS:
                    r_cfg.postlow_ticks <= i_cfg_data[ssi_pkg::TICK_W-1:0];
                ssi_pkg::REG_STORED_ZERO:
                    r_cfg.stored_zero <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ssi_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (in_acc),
        .i_mode      (i_mode),
        .i_data_line (i_data_line),
        .i_cfg       (r_cfg),
        .o_next      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_clock_level      = r_result.clock_level;
    assign o_busy_res         = r_result.busy_res;
    assign o_frame_done       = r_result.frame_done;
    assign o_multiturn_value  = r_result.multiturn_value;
    assign o_singleturn_value = r_result.singleturn_value;
    assign o_status_byte      = r_result.status_byte;
    assign o_zero_offset      = r_result.zero_offset;

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted word left no result word");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_result)))
        else $error("stalled result word lost or changed");

endmodule
`default_nettype wire
